FILE: src/aet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the activity episode tracker.
// No dependencies; imported by every module of the block.
package aet_pkg;

	localparam int TIME_BITS_DEF     = 48;
	localparam int INTERVAL_BITS_DEF = 24;
	localparam int SEQ_BITS_DEF      = 32;
	localparam int GRACE_BITS        = 24;
	localparam int PHASE_BITS        = 2;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_ACTIVE = 2'd1,
		MODE_GRACE  = 2'd2
	} aet_mode_t;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_STARTED = 2'd0,
		PH_ONGOING = 2'd1,
		PH_ENDED   = 2'd2
	} aet_phase_t;

endpackage

FILE: src/aet_in_reg.sv
`timescale 1ns / 1ps
// Input register of the tracker: holds one observation and its time step.
// Uses aet_pkg.
module aet_in_reg import aet_pkg::*; #(
	parameter int TIME_BITS     = TIME_BITS_DEF,
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_combat,
	input  logic                     suspended,
	input  logic [TIME_BITS-1:0]     now_ms,
	input  logic [INTERVAL_BITS-1:0] interval_ms,
	input  logic                     advance,
	output logic                     valid_s1,
	output logic                     combat_s1,
	output logic                     pause_s1,
	output logic [INTERVAL_BITS-1:0] interval_s1,
	output logic [TIME_BITS-1:0]     step_s1
);

	logic                 seen_q;
	logic                 paused_q;
	logic [TIME_BITS-1:0] last_time_q;
	logic [TIME_BITS-1:0] step_d;
	logic                 take;

	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	// step counts as zero on the first request, after a pause and when time runs back
	always_comb begin
		step_d = '0;
		if (seen_q && !paused_q && (now_ms > last_time_q)) begin
			step_d = now_ms - last_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			seen_q      <= 1'b0;
			paused_q    <= 1'b0;
			last_time_q <= '0;
		end else begin
			if (take) begin
				valid_s1    <= 1'b1;
				seen_q      <= 1'b1;
				paused_q    <= suspended;
				last_time_q <= now_ms;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			combat_s1   <= in_combat;
			pause_s1    <= suspended;
			interval_s1 <= interval_ms;
			step_s1     <= step_d;
		end
	end

endmodule

FILE: src/aet_core.sv
`timescale 1ns / 1ps
// Episode state machine, timers, heartbeat schedule and grace register.
// Uses aet_pkg for mode and phase codes.
module aet_core import aet_pkg::*; #(
	parameter int TIME_BITS     = TIME_BITS_DEF,
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
	parameter int SEQ_BITS      = SEQ_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [GRACE_BITS-1:0]    cfg_data,
	input  logic                     advance,
	input  logic                     combat_s1,
	input  logic                     pause_s1,
	input  logic [INTERVAL_BITS-1:0] interval_s1,
	input  logic [TIME_BITS-1:0]     step_s1,
	output logic                     res_valid,
	output aet_phase_t               res_phase,
	output logic [SEQ_BITS-1:0]      res_seq,
	output logic [TIME_BITS-1:0]     res_elapsed
);

	aet_mode_t                mode_q, mode_d;
	logic [GRACE_BITS-1:0]    exit_grace_q;
	logic [TIME_BITS-1:0]     active_q, active_d;
	logic [TIME_BITS-1:0]     grace_q, grace_d;
	logic [INTERVAL_BITS-1:0] cur_int_q, cur_int_d;
	logic [TIME_BITS-1:0]     next_due_q, next_due_d;
	logic [SEQ_BITS-1:0]      seq_q, seq_d;

	logic [INTERVAL_BITS-1:0] want;
	logic [TIME_BITS-1:0]     want_ext;
	logic [TIME_BITS-1:0]     grace_ext;
	logic [TIME_BITS-1:0]     acc_base, acc_sat;
	logic [TIME_BITS:0]       acc_sum;
	logic [TIME_BITS-1:0]     due_base, due_sat;
	logic [TIME_BITS:0]       due_sum;
	logic [SEQ_BITS-1:0]      seq_inc;
	logic                     grace_zero;
	logic                     grace_done;
	logic                     int_change;

	assign want       = (interval_s1 == '0) ? INTERVAL_BITS'(1) : interval_s1;
	assign want_ext   = TIME_BITS'(want);
	assign grace_ext  = TIME_BITS'(exit_grace_q);
	assign int_change = (want != cur_int_q);
	assign seq_inc    = seq_q + SEQ_BITS'(1);

	// accumulate the step into active time, or into grace time while waiting
	assign acc_base = (mode_q == MODE_GRACE) ? grace_q : active_q;
	assign acc_sum  = {1'b0, acc_base} + {1'b0, step_s1};
	assign acc_sat  = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];

	// next heartbeat: from the updated active time while active, held time in grace
	assign due_base = (mode_q == MODE_ACTIVE) ? acc_sat : active_q;
	assign due_sum  = {1'b0, due_base} + {1'b0, want_ext};
	assign due_sat  = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];

	assign grace_zero = (exit_grace_q == '0);
	assign grace_done = (acc_sat >= grace_ext);

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (!pause_s1) begin
			case (mode_q)
				MODE_ACTIVE: begin
					if (!combat_s1) begin
						mode_d = grace_zero ? MODE_IDLE : MODE_GRACE;
					end
				end
				MODE_GRACE: begin
					if (combat_s1) begin
						mode_d = MODE_ACTIVE;
					end else if (grace_done) begin
						mode_d = MODE_IDLE;
					end
				end
				default: begin
					mode_d = combat_s1 ? MODE_ACTIVE : MODE_IDLE;
				end
			endcase
		end
	end

	// timers, schedule and result
	always_comb begin
		active_d    = active_q;
		grace_d     = grace_q;
		cur_int_d   = cur_int_q;
		next_due_d  = next_due_q;
		seq_d       = seq_q;
		res_valid   = 1'b0;
		res_phase   = PH_STARTED;
		res_seq     = seq_q;
		res_elapsed = active_q;
		if (!pause_s1) begin
			case (mode_q)
				MODE_ACTIVE: begin
					if (!combat_s1) begin
						grace_d = '0;
						if (grace_zero) begin
							seq_d     = seq_inc;
							res_valid = 1'b1;
							res_phase = PH_ENDED;
							res_seq   = seq_inc;
						end
					end else begin
						active_d    = acc_sat;
						res_elapsed = acc_sat;
						if (int_change) begin
							cur_int_d  = want;
							next_due_d = due_sat;
						end else if (acc_sat >= next_due_q) begin
							seq_d      = seq_inc;
							next_due_d = due_sat;
							res_valid  = 1'b1;
							res_phase  = PH_ONGOING;
							res_seq    = seq_inc;
						end
					end
				end
				MODE_GRACE: begin
					if (combat_s1) begin
						grace_d = '0;
						if (int_change) begin
							cur_int_d  = want;
							next_due_d = due_sat;
						end
					end else if (grace_done) begin
						grace_d   = '0;
						seq_d     = seq_inc;
						res_valid = 1'b1;
						res_phase = PH_ENDED;
						res_seq   = seq_inc;
					end else begin
						grace_d = acc_sat;
					end
				end
				default: begin
					if (combat_s1) begin
						active_d    = '0;
						grace_d     = '0;
						cur_int_d   = want;
						next_due_d  = want_ext;
						seq_d       = '0;
						res_valid   = 1'b1;
						res_phase   = PH_STARTED;
						res_seq     = '0;
						res_elapsed = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			exit_grace_q <= '0;
			active_q     <= '0;
			grace_q      <= '0;
			cur_int_q    <= INTERVAL_BITS'(1);
			next_due_q   <= TIME_BITS'(1);
			seq_q        <= '0;
		end else begin
			if (cfg_valid) begin
				exit_grace_q <= cfg_data;
			end
			if (advance) begin
				mode_q     <= mode_d;
				active_q   <= active_d;
				grace_q    <= grace_d;
				cur_int_q  <= cur_int_d;
				next_due_q <= next_due_d;
				seq_q      <= seq_d;
			end
		end
	end

endmodule

FILE: src/aet_out_reg.sv
`timescale 1ns / 1ps
// Result register of the tracker: holds one result until the sink takes it.
// Uses aet_pkg for the phase type.
module aet_out_reg import aet_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int SEQ_BITS  = SEQ_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 res_valid,
	input  aet_phase_t           res_phase,
	input  logic [SEQ_BITS-1:0]  res_seq,
	input  logic [TIME_BITS-1:0] res_elapsed,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output aet_phase_t           phase_q,
	output logic [SEQ_BITS-1:0]  seq_q,
	output logic [TIME_BITS-1:0] elapsed_q
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			phase_q   <= res_phase;
			seq_q     <= res_seq;
			elapsed_q <= res_elapsed;
		end
	end

endmodule

FILE: src/activity_episode_tracker.sv
`timescale 1ns / 1ps
// Activity episode tracker: turns timestamped observations into started,
// ongoing and ended results. A request passes the input register, then the state
// update into the result register; one request is taken every cycle, paced only
// by the result register draining.
// arst_n clears mode, timers and counters asynchronously; exit grace resets to 0.
module activity_episode_tracker import aet_pkg::*; #(
	parameter int TIME_BITS     = TIME_BITS_DEF,
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
	parameter int SEQ_BITS      = SEQ_BITS_DEF,
	localparam int IN_W         = 2 + TIME_BITS + INTERVAL_BITS,
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W        = SEQ_BITS + TIME_BITS,
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: exit grace time in ms
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [GRACE_BITS-1:0]  cfg_data,
	// observations
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // in_combat, suspended, now_ms, interval_ms, pad
	// results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // sequence_res, elapsed_ms, zero pad
	output logic [PHASE_BITS-1:0]  m_tuser   // phase
);

	logic                     advance;
	logic                     out_free;
	logic                     valid_s1;
	logic                     combat_s1;
	logic                     pause_s1;
	logic [INTERVAL_BITS-1:0] interval_s1;
	logic [TIME_BITS-1:0]     step_s1;
	logic                     res_valid;
	aet_phase_t               res_phase;
	logic [SEQ_BITS-1:0]      res_seq;
	logic [TIME_BITS-1:0]     res_elapsed;
	aet_phase_t               phase_q;
	logic [SEQ_BITS-1:0]      seq_q;
	logic [TIME_BITS-1:0]     elapsed_q;

	// configuration writes are always taken; the user must send them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// advance the held observation whenever the result register can take its outcome
	assign advance = valid_s1 && out_free;

	aet_in_reg #(
		.TIME_BITS     (TIME_BITS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_combat   (s_tdata[0]),
		.suspended   (s_tdata[1]),
		.now_ms      (s_tdata[2 +: TIME_BITS]),
		.interval_ms (s_tdata[2 + TIME_BITS +: INTERVAL_BITS]),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.combat_s1   (combat_s1),
		.pause_s1    (pause_s1),
		.interval_s1 (interval_s1),
		.step_s1     (step_s1)
	);

	aet_core #(
		.TIME_BITS     (TIME_BITS),
		.INTERVAL_BITS (INTERVAL_BITS),
		.SEQ_BITS      (SEQ_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.advance     (advance),
		.combat_s1   (combat_s1),
		.pause_s1    (pause_s1),
		.interval_s1 (interval_s1),
		.step_s1     (step_s1),
		.res_valid   (res_valid),
		.res_phase   (res_phase),
		.res_seq     (res_seq),
		.res_elapsed (res_elapsed)
	);

	aet_out_reg #(
		.TIME_BITS (TIME_BITS),
		.SEQ_BITS  (SEQ_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.res_valid   (res_valid),
		.res_phase   (res_phase),
		.res_seq     (res_seq),
		.res_elapsed (res_elapsed),
		.free        (out_free),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.phase_q     (phase_q),
		.seq_q       (seq_q),
		.elapsed_q   (elapsed_q)
	);

	// pack the result: sequence in the low bits, elapsed above, zeros to the byte
	assign m_tdata = OUT_TDATA_W'({elapsed_q, seq_q});
	assign m_tuser = phase_q;

endmodule

FILE: bench/episode_checker.sv
`timescale 1ns / 1ps
// Checker for the activity episode tracker: watches the three channels, predicts the
// episode results and compares them field by field. Depends on aet_pkg.
module episode_checker import aet_pkg::*; #(
	localparam int TB          = TIME_BITS_DEF,
	localparam int IB          = INTERVAL_BITS_DEF,
	localparam int SB          = SEQ_BITS_DEF,
	localparam int IN_TDATA_W  = ((2 + TB + IB + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((SB + TB + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [GRACE_BITS-1:0]  cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic [PHASE_BITS-1:0]  m_tuser,
	output int                     mismatches,
	output int                     events_due,
	output int                     obs_seen,
	output int                     started_seen,
	output int                     heartbeats_seen,
	output int                     ended_seen
);

	localparam logic [TB-1:0] TIME_MAX = '1;

	typedef struct {
		aet_phase_t    phase;
		logic [SB-1:0] seq;
		logic [TB-1:0] elapsed;
	} episode_event_t;

	episode_event_t pending_events[$];

	// predicted block state
	logic [GRACE_BITS-1:0] grace_limit;
	aet_mode_t             mode;
	logic                  seen_obs;
	logic                  was_paused;
	logic [TB-1:0]         last_ms;
	logic [TB-1:0]         active_ms;
	logic [TB-1:0]         grace_ms;
	logic [IB-1:0]         cur_ivl;
	logic [TB-1:0]         due_ms;
	logic [SB-1:0]         seq_no;

	function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
		logic [TB:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		sat_add = (sum >= {1'b0, TIME_MAX}) ? TIME_MAX : sum[TB-1:0];
	endfunction

	task automatic post_event(input aet_phase_t ph);
		episode_event_t ev;
		ev.phase   = ph;
		ev.seq     = seq_no;
		ev.elapsed = active_ms;
		pending_events.push_back(ev);
	endtask

	task automatic close_if_due();
		if (grace_ms >= {{(TB-GRACE_BITS){1'b0}}, grace_limit}) begin
			seq_no   = seq_no + SB'(1);
			post_event(PH_ENDED);
			mode     = MODE_IDLE;
			grace_ms = '0;
		end
	endtask

	task automatic track_observation(input logic [IN_TDATA_W-1:0] d);
		logic          act;
		logic          pause;
		logic [TB-1:0] now;
		logic [TB-1:0] step;
		logic [IB-1:0] want;
		act   = d[0];
		pause = d[1];
		now   = d[2 +: TB];
		want  = d[2+TB +: IB];
		step  = '0;
		// no step on the first observation, after a pause, or when time runs backwards
		if (seen_obs && !was_paused && now > last_ms)
			step = now - last_ms;
		seen_obs = 1'b1;
		last_ms  = now;
		if (pause) begin
			was_paused = 1'b1;
		end else begin
			was_paused = 1'b0;
			if (want == '0)
				want = IB'(1);
			case (mode)
				MODE_ACTIVE: begin
					if (!act) begin
						mode     = MODE_GRACE;
						grace_ms = '0;
						close_if_due();
					end else begin
						active_ms = sat_add(active_ms, step);
						if (want != cur_ivl) begin
							cur_ivl = want;
							due_ms  = sat_add(active_ms, TB'(cur_ivl));
						end else if (active_ms >= due_ms) begin
							seq_no = seq_no + SB'(1);
							due_ms = sat_add(active_ms, TB'(cur_ivl));
							post_event(PH_ONGOING);
						end
					end
				end
				MODE_GRACE: begin
					if (act) begin
						if (want != cur_ivl) begin
							cur_ivl = want;
							due_ms  = sat_add(active_ms, TB'(cur_ivl));
						end
						mode     = MODE_ACTIVE;
						grace_ms = '0;
					end else begin
						grace_ms = sat_add(grace_ms, step);
						close_if_due();
					end
				end
				default: begin
					if (act) begin
						mode      = MODE_ACTIVE;
						active_ms = '0;
						grace_ms  = '0;
						cur_ivl   = want;
						due_ms    = TB'(want);
						seq_no    = '0;
						post_event(PH_STARTED);
					end
				end
			endcase
		end
	endtask

	task automatic check_result();
		episode_event_t exp_ev;
		logic [SB-1:0]  got_seq;
		logic [TB-1:0]  got_elapsed;
		got_seq     = m_tdata[0 +: SB];
		got_elapsed = m_tdata[SB +: TB];
		if (pending_events.size() == 0) begin
			$error("unexpected result: phase %0d sequence_res %0d elapsed_ms %0d",
				m_tuser, got_seq, got_elapsed);
			mismatches++;
		end else begin
			exp_ev = pending_events.pop_front();
			case (exp_ev.phase)
				PH_STARTED: started_seen++;
				PH_ONGOING: heartbeats_seen++;
				default:    ended_seen++;
			endcase
			if (m_tuser !== exp_ev.phase) begin
				$error("phase: expected %0d, got %0d", exp_ev.phase, m_tuser);
				mismatches++;
			end
			if (got_seq !== exp_ev.seq) begin
				$error("sequence_res: expected %0d, got %0d", exp_ev.seq, got_seq);
				mismatches++;
			end
			if (got_elapsed !== exp_ev.elapsed) begin
				$error("elapsed_ms: expected %0d, got %0d", exp_ev.elapsed, got_elapsed);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_events.delete();
			grace_limit     = '0;
			mode            = MODE_IDLE;
			seen_obs        = 1'b0;
			was_paused      = 1'b0;
			last_ms         = '0;
			active_ms       = '0;
			grace_ms        = '0;
			cur_ivl         = IB'(1);
			due_ms          = TB'(1);
			seq_no          = '0;
			mismatches      = 0;
			events_due      = 0;
			obs_seen        = 0;
			started_seen    = 0;
			heartbeats_seen = 0;
			ended_seen      = 0;
		end else begin
			// results leave only after their request has passed the input and result registers, so drain before predicting
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_valid && cfg_ready)
				grace_limit = cfg_data;
			if (s_tvalid && s_tready) begin
				obs_seen++;
				track_observation(s_tdata);
			end
			events_due = pending_events.size();
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the activity episode tracker bench: clock, reset, stimulus and verdict.
// Depends on aet_pkg, activity_episode_tracker and episode_checker.
module testbench;
	import aet_pkg::*;

	localparam int TB          = TIME_BITS_DEF;
	localparam int IB          = INTERVAL_BITS_DEF;
	localparam int SB          = SEQ_BITS_DEF;
	localparam int IN_TDATA_W  = ((2 + TB + IB + 7) / 8) * 8;
	localparam int IN_PAD      = IN_TDATA_W - 2 - TB - IB;
	localparam int OUT_TDATA_W = ((SB + TB + 7) / 8) * 8;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 222;
	// cycles in which no channel moves anything before the run is abandoned
	localparam int STALL_LIMIT = 5000;
	// the result register sits behind the input register; allow a margin
	localparam int SETTLE_CYCLES = 6;

	localparam logic [TB-1:0] TIME_ALL = '1;
	localparam logic [IB-1:0] IVL_ALL  = '1;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [GRACE_BITS-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // in_combat, suspended, now_ms, interval_ms, pad
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // sequence_res, elapsed_ms, pad
	logic [PHASE_BITS-1:0]  m_tuser;   // phase

	int mismatches;
	int events_due;
	int obs_seen;
	int started_seen;
	int heartbeats_seen;
	int ended_seen;

	// idling odds in percent, changed per phase
	int src_idle_pct;
	int sink_stall_pct;
	// stimulus bookkeeping
	logic [TB-1:0]         tb_now;
	logic [GRACE_BITS-1:0] cur_grace;
	int                    obs_sent;
	int                    grace_settings;

	always #2 clk = ~clk;

	activity_episode_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	episode_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatches      (mismatches),
		.events_due      (events_due),
		.obs_seen        (obs_seen),
		.started_seen    (started_seen),
		.heartbeats_seen (heartbeats_seen),
		.ended_seen      (ended_seen)
	);

	// Result side: stall at random, redrawn on every falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Offer one observation request and hold it until it is taken. Entered and left just
	// after a falling edge; valid only drops when the sender chooses to idle.
	task automatic send_obs(input logic act, input logic susp, input logic [TB-1:0] t,
			input logic [IB-1:0] ivl);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{IN_PAD{1'b0}}, ivl, t, susp, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (!susp)
			obs_sent++;
	endtask

	// Hold the sender off until every predicted result has come out, then let the
	// pipeline run dry; observations that cause nothing may still be in flight.
	task automatic settle_block();
		s_tvalid = 1'b0;
		while (events_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_grace(input logic [GRACE_BITS-1:0] v);
		settle_block();
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_grace = v;
		grace_settings++;
	endtask

	// Mostly short heartbeat intervals so that heartbeats are frequent; a few zero and
	// full-range ones.
	function automatic logic [IB-1:0] pick_interval();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			pick_interval = '0;
		else if (r < 10)
			pick_interval = IB'($urandom);
		else
			pick_interval = IB'($urandom_range(1, 30));
	endfunction

	function automatic logic [TB-1:0] active_step(input logic [IB-1:0] ivl);
		int lim;
		lim = (ivl > 30) ? 61 : 2 * int'(ivl) + 1;
		if ($urandom_range(99) < 3)
			active_step = TB'($urandom);
		else
			active_step = TB'($urandom_range(0, lim));
	endfunction

	// Inactive gaps scaled to the current grace time; a few large jumps so that even
	// the longest grace setting lets episodes end.
	function automatic logic [TB-1:0] idle_step();
		int lim;
		lim = (cur_grace < 40) ? int'(cur_grace) + 2 : 40;
		if ($urandom_range(99) < 5)
			idle_step = TB'($urandom);
		else
			idle_step = TB'($urandom_range(0, lim));
	endfunction

	// Offset the timestamp backwards now and then; the block must count that as zero.
	function automatic logic [TB-1:0] jitter(input logic [TB-1:0] t);
		if ($urandom_range(99) < 4)
			jitter = t - TB'($urandom_range(1, 50));
		else
			jitter = t;
	endfunction

	// One well-formed episode with random content: start, a run of active observations
	// with occasional interval changes and pauses, then an inactive tail that may
	// briefly return to activity.
	task automatic run_episode();
		logic [IB-1:0] ivl;
		int            n_act;
		int            n_idle;
		ivl = pick_interval();
		if ($urandom_range(9) == 0)
			send_obs(1'($urandom_range(1)), 1'b1, tb_now, pick_interval());
		tb_now = tb_now + TB'($urandom_range(0, 20));
		send_obs(1'b1, 1'b0, tb_now, ivl);
		n_act = $urandom_range(1, 12);
		repeat (n_act) begin
			if ($urandom_range(99) < 12)
				ivl = pick_interval();
			tb_now = tb_now + active_step(ivl);
			send_obs(1'b1, ($urandom_range(99) < 6), jitter(tb_now), ivl);
		end
		n_idle = $urandom_range(1, 8);
		repeat (n_idle) begin
			if ($urandom_range(99) < 5)
				ivl = pick_interval();
			tb_now = tb_now + idle_step();
			send_obs(($urandom_range(99) < 12), ($urandom_range(99) < 6), jitter(tb_now),
				ivl);
		end
	endtask

	// A burst of observations with every field drawn over its full range.
	task automatic run_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			send_obs(1'($urandom_range(1)), ($urandom_range(99) < 25),
				TB'({$urandom, $urandom}), IB'($urandom));
		end
	endtask

	function automatic logic [GRACE_BITS-1:0] grace_for_phase(input int p);
		case (p)
			0:       grace_for_phase = '0;
			1:       grace_for_phase = '1;
			2:       grace_for_phase = GRACE_BITS'(1);
			3:       grace_for_phase = GRACE_BITS'(25);
			4:       grace_for_phase = GRACE_BITS'(120);
			5:       grace_for_phase = GRACE_BITS'($urandom_range(2, 300));
			6:       grace_for_phase = GRACE_BITS'(60);
			default: grace_for_phase = GRACE_BITS'(8);
		endcase
	endfunction

	// Watchdog: abandon the run once nothing has moved on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("activity_episode_tracker verification failed");
		$finish;
	end

	initial begin : stimulus
		int p;
		int phase_end;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		tb_now         = TB'(1000);
		cur_grace      = '0;
		obs_sent       = 0;
		grace_settings = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, grace at its reset value of zero.
		send_obs(1'b0, 1'b0, TB'(0), IB'(0));          // idle, first observation
		send_obs(1'b1, 1'b0, TB'(5), IB'(0));          // start; zero interval acts as one
		send_obs(1'b1, 1'b0, TB'(7), IB'(1));          // heartbeat due
		send_obs(1'b1, 1'b1, TB'(100), IB'(1));        // paused
		send_obs(1'b1, 1'b0, TB'(200), IB'(1));        // step after a pause counts as zero
		send_obs(1'b1, 1'b0, TB'(3), IB'(1));          // time runs backwards
		send_obs(1'b1, 1'b0, TB'(4), IB'(5));          // interval change, reschedule only
		send_obs(1'b0, 1'b0, TB'(10), IB'(5));         // leave; zero grace ends at once
		send_obs(1'b1, 1'b0, TB'(0), IVL_ALL);         // start with the widest interval
		send_obs(1'b1, 1'b0, TIME_ALL, IVL_ALL);       // active time saturates
		send_obs(1'b1, 1'b0, TIME_ALL, IVL_ALL);       // saturated schedule still fires
		send_obs(1'b0, 1'b0, TB'(0), IVL_ALL);         // end carrying the saturated time

		// Directed, grace of ten: return during grace, pause in grace, end.
		write_grace(GRACE_BITS'(10));
		send_obs(1'b1, 1'b0, TB'(1000), IB'(3));
		send_obs(1'b0, 1'b0, TB'(1004), IB'(3));
		send_obs(1'b0, 1'b0, TB'(1008), IB'(3));
		send_obs(1'b1, 1'b0, TB'(1009), IB'(7));       // return with an interval change
		send_obs(1'b0, 1'b0, TB'(1010), IB'(7));
		send_obs(1'b0, 1'b1, TB'(1012), IB'(7));       // paused while in grace
		send_obs(1'b0, 1'b0, TB'(5000), IB'(7));
		send_obs(1'b0, 1'b0, TB'(5011), IB'(7));       // grace reached
		send_obs(1'b1, 1'b1, TIME_ALL, IVL_ALL);       // paused with every bit set

		// Random phases: each sets a grace time and an idling pattern.
		for (p = 0; p < PHASES; p++) begin
			write_grace(grace_for_phase(p));
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
				default: begin src_idle_pct = 16; sink_stall_pct = 16; end
			endcase
			phase_end = obs_sent + PHASE_ITEMS;
			while (obs_sent < phase_end) begin
				if ($urandom_range(99) < 10)
					run_noise();
				else
					run_episode();
			end
		end

		// Drain, then give the pipeline time to show any stray result.
		s_tvalid = 1'b0;
		while (events_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES + 2) @(negedge clk);

		$display("run covered %0d observations under %0d grace settings", obs_seen,
			grace_settings);
		$display("results checked: %0d started, %0d heartbeat, %0d ended", started_seen,
			heartbeats_seen, ended_seen);
		if (mismatches == 0 && events_due == 0)
			$display("activity_episode_tracker verification clean");
		else
			$display("activity_episode_tracker verification failed");
		$finish;
	end

endmodule
